// ===== hw/rtl/circular_deque_core_assert.svh =====
// Assertion macros for the deque RTL; cdq_dpath is the file that includes them.
`ifndef CIRCULAR_DEQUE_CORE_ASSERT_SVH
`define CIRCULAR_DEQUE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CDQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`CDQ_ASSERT(lbl, clk, rst_n, !(expr), msg)
`else
`define CDQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== hw/rtl/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int OP_W   = 3;
	localparam int STAT_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_PEEK_FRONT = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cdq_if.sv =====
`default_nettype none

interface cdq_req_if;
	logic                                  valid;
	logic                                  ready;
	logic        [cdq_pkg::OP_W-1:0]       op;
	logic signed [cdq_pkg::DATA_W-1:0]     value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface cdq_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [cdq_pkg::DATA_W-1:0]     data_out;
	logic        [cdq_pkg::STAT_W-1:0]     status;
	logic        [cdq_pkg::CNT_W-1:0]      occupancy;
	logic                                  is_empty_flag;
	logic                                  is_full_flag;

	modport source (output valid, output data_out, output status, output occupancy,
		output is_empty_flag, output is_full_flag, input ready);
	modport sink (input valid, input data_out, input status, input occupancy,
		input is_empty_flag, input is_full_flag, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cdq_ctrl.sv =====
`default_nettype none

module cdq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output cdq_pkg::cmd_t      cmd
);
	import cdq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	assign req_ready  = (state_q == S_IDLE);
	assign cmd.load   = req_valid && (state_q == S_IDLE);
	// The result register must be free, or freed this cycle, before a request commits.
	assign cmd.commit = (state_q == S_RUN) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid  = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rsp_valid_q && rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (req_valid) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (cmd.commit) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cdq_dpath.sv =====
`default_nettype none

`include "circular_deque_core_assert.svh"

module cdq_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cdq_pkg::cmd_t                 cmd,
	input  wire logic [cdq_pkg::OP_W-1:0]      op,
	input  wire logic signed [cdq_pkg::DATA_W-1:0] value,
	output logic signed [cdq_pkg::DATA_W-1:0]  data_out,
	output logic [cdq_pkg::STAT_W-1:0]         status,
	output logic [cdq_pkg::CNT_W-1:0]          occupancy,
	output logic                               is_empty_flag,
	output logic                               is_full_flag
);
	import cdq_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [IDX_W-1:0]  head_n, tail_n, waddr, raddr;
	logic [CNT_W-1:0]  cnt_n;
	logic              we;
	logic [DATA_W-1:0] data_n;
	stat_t             stat_n;
	logic              full, empty;

	logic [DATA_W-1:0] data_q;
	logic [STAT_W-1:0] stat_q;
	logic [CNT_W-1:0]  occ_q;
	logic              empty_q, full_q;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	// Pop back reads the tail slot; every other read looks at the front.
	assign raddr = (op == OP_POP_BACK) ? tail_q : head_q;
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		cnt_n  = cnt_q;
		we     = 1'b0;
		waddr  = '0;
		data_n = '0;
		stat_n = STAT_DONE;
		case (op_q)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (full) begin
					stat_n = STAT_FULL;
				end else begin
					we    = 1'b1;
					cnt_n = cnt_q + 1'b1;
					if (empty) begin
						// A push into an empty ring restarts both ends at slot zero.
						head_n = '0;
						tail_n = '0;
						waddr  = '0;
					end else if (op_q == OP_PUSH_BACK) begin
						tail_n = idx_inc(tail_q);
						waddr  = tail_n;
					end else begin
						head_n = idx_dec(head_q);
						waddr  = head_n;
					end
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					stat_n = STAT_EMPTY;
				end else begin
					data_n = rd_q;
					tail_n = idx_dec(tail_q);
					cnt_n  = cnt_q - 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					stat_n = STAT_EMPTY;
				end else begin
					data_n = rd_q;
					head_n = idx_inc(head_q);
					cnt_n  = cnt_q - 1'b1;
				end
			end
			OP_PEEK_FRONT: begin
				if (empty) begin
					stat_n = STAT_EMPTY;
				end else begin
					data_n = rd_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q    <= mem_q[raddr];
			op_q    <= op;
			value_q <= value;
		end
		if (cmd.commit && we) begin
			mem_q[waddr] <= value_q;
		end
		if (cmd.commit) begin
			data_q  <= data_n;
			stat_q  <= stat_n;
			occ_q   <= cnt_n;
			empty_q <= (cnt_n == '0);
			full_q  <= (cnt_n == CNT_W'(DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.commit) begin
			head_q <= head_n;
			tail_q <= tail_n;
			cnt_q  <= cnt_n;
		end
	end

	assign data_out      = data_q;
	assign status        = stat_q;
	assign occupancy     = occ_q;
	assign is_empty_flag = empty_q;
	assign is_full_flag  = full_q;

	// Back slot as implied by the front slot and the count.
	logic [IDX_W:0]   back_sum;
	logic [IDX_W-1:0] back_calc;
	assign back_sum  = {1'b0, head_q} + (IDX_W + 1)'(cnt_q - 1'b1);
	assign back_calc = (back_sum >= (IDX_W + 1)'(DEPTH)) ?
		IDX_W'(back_sum - (IDX_W + 1)'(DEPTH)) : back_sum[IDX_W-1:0];

	`CDQ_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CNT_W'(DEPTH),
		"count above depth")
	`CDQ_ASSERT_NEVER(a_idx_range, clk, arst_n,
		(head_q > IDX_W'(DEPTH - 1)) || (tail_q > IDX_W'(DEPTH - 1)),
		"ring index out of range")
	`CDQ_ASSERT(a_ring_span, clk, arst_n, (cnt_q != '0) |-> (tail_q == back_calc),
		"tail does not match head and count")
	`CDQ_ASSERT(a_full_flag, clk, arst_n,
		(cmd.commit && (stat_n == STAT_FULL)) |=> full_q,
		"full refusal without full flag")

endmodule

`default_nettype wire

// ===== hw/rtl/circular_deque_core.sv =====
// Double-ended queue of DEPTH signed 32-bit words kept in a ring memory. Each request on
// req pushes at the back or front, pops from the back or front, or peeks at the front, and
// yields exactly one response on rsp with the word read, a status (done, full, empty) and
// the occupancy with empty and full flags after the request; a reserved opcode reports done.
// The ring slot is read into a register on acceptance; a commit then updates the indices,
// writes the slot and loads the response register; only then is a new request accepted.
// A response waiting for rsp.ready holds back the commit of the next request, not its acceptance.
`default_nettype none

module circular_deque_core (
	input  wire logic clk,
	input  wire logic arst_n,
	cdq_req_if.sink   req,
	cdq_rsp_if.source rsp
);
	import cdq_pkg::*;

	cmd_t cmd;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	cdq_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (req.op),
		.value         (req.value),
		.data_out      (rsp.data_out),
		.status        (rsp.status),
		.occupancy     (rsp.occupancy),
		.is_empty_flag (rsp.is_empty_flag),
		.is_full_flag  (rsp.is_full_flag)
	);

endmodule

`default_nettype wire

// ===== sim/circular_deque_core_tb.sv =====
`timescale 1ns / 100ps

module circular_deque_core_tb;
	import cdq_pkg::*;

	localparam int IDLE_PCT     = 28;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		stat_t                    status;
		logic [CNT_W-1:0]         occ;
		logic                     empty;
		logic                     full;
	} deque_rsp_t;

	logic clk;
	logic arst_n;
	logic no_idle = 1'b0;
	int   mismatches = 0;
	int   rsp_seen = 0;

	// Shadow copy of the ring, advanced once per accepted request.
	logic signed [DATA_W-1:0] ring_mem [DEPTH];
	logic [IDX_W-1:0]         ring_head = '0;
	logic [IDX_W-1:0]         ring_tail = '0;
	logic [CNT_W-1:0]         ring_count = '0;

	deque_rsp_t expected_rsps [$];

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	circular_deque_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic deque_rsp_t deque_apply(op_t op, logic signed [DATA_W-1:0] value);
		deque_rsp_t r;
		logic was_full;
		logic was_empty;
		r.data = '0;
		r.status = STAT_DONE;
		was_full = (ring_count == DEPTH);
		was_empty = (ring_count == 0);
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (was_full) begin
					r.status = STAT_FULL;
				end else begin
					// The first word always lands in slot zero, whichever end it enters.
					if (was_empty) begin
						ring_head = '0;
						ring_tail = '0;
						ring_mem[0] = value;
					end else if (op == OP_PUSH_BACK) begin
						ring_tail = IDX_W'((int'(ring_tail) + 1) % DEPTH);
						ring_mem[ring_tail] = value;
					end else begin
						ring_head = IDX_W'((int'(ring_head) + DEPTH - 1) % DEPTH);
						ring_mem[ring_head] = value;
					end
					ring_count = ring_count + 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (was_empty) begin
					r.status = STAT_EMPTY;
				end else begin
					r.data = ring_mem[ring_tail];
					ring_tail = IDX_W'((int'(ring_tail) + DEPTH - 1) % DEPTH);
					ring_count = ring_count - 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (was_empty) begin
					r.status = STAT_EMPTY;
				end else begin
					r.data = ring_mem[ring_head];
					ring_head = IDX_W'((int'(ring_head) + 1) % DEPTH);
					ring_count = ring_count - 1'b1;
				end
			end
			OP_PEEK_FRONT: begin
				if (was_empty) begin
					r.status = STAT_EMPTY;
				end else begin
					r.data = ring_mem[ring_head];
				end
			end
			default: begin
			end
		endcase
		r.occ = ring_count;
		r.empty = (ring_count == 0);
		r.full = (ring_count == DEPTH);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		$display("response %0d: %s is %0h, expected %0h", rsp_seen, field, got, want);
		mismatches++;
	endtask

	// Requests are predicted before responses are checked, so a response in the
	// same cycle as its own request would still find its expectation.
	always @(posedge clk) begin : rsp_monitor
		deque_rsp_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				expected_rsps.push_back(deque_apply(op_t'(req_ch.op), req_ch.value));
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected response data_out", rsp_ch.data_out, '0);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.data_out !== want.data)
						report_mismatch("data_out", rsp_ch.data_out, want.data);
					if (rsp_ch.status !== want.status)
						report_mismatch("status", DATA_W'(rsp_ch.status),
							DATA_W'(want.status));
					if (rsp_ch.occupancy !== want.occ)
						report_mismatch("occupancy", DATA_W'(rsp_ch.occupancy),
							DATA_W'(want.occ));
					if (rsp_ch.is_empty_flag !== want.empty)
						report_mismatch("is_empty_flag", DATA_W'(rsp_ch.is_empty_flag),
							DATA_W'(want.empty));
					if (rsp_ch.is_full_flag !== want.full)
						report_mismatch("is_full_flag", DATA_W'(rsp_ch.is_full_flag),
							DATA_W'(want.full));
				end
				rsp_seen++;
			end
		end
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Leaves valid high after acceptance; the next call or drain decides its value
	// in the same time step.
	task automatic send_request(input logic [OP_W-1:0] op,
		input logic signed [DATA_W-1:0] value);
		while (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.value <= value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) return 32'sh8000_0000;
		if (roll < 6) return 32'sh7fff_ffff;
		if (roll < 8) return '0;
		if (roll < 10) return -32'sd1;
		return $urandom;
	endfunction

	function automatic logic [OP_W-1:0] pick_push();
		return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
	endfunction

	function automatic logic [OP_W-1:0] pick_pop();
		return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	function automatic logic [OP_W-1:0] pick_reserved();
		return OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
	endfunction

	function automatic logic [OP_W-1:0] pick_op(int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < push_pct) return pick_push();
		roll = $urandom_range(0, 99);
		if (roll < 5) return pick_reserved();
		if (roll < 20) return OP_PEEK_FRONT;
		return pick_pop();
	endfunction

	task automatic test_directed();
		send_request(OP_POP_BACK, -32'sd1);
		send_request(OP_POP_FRONT, 32'sh7fff_ffff);
		send_request(OP_PEEK_FRONT, 32'sh8000_0000);
		send_request(OP_RESERVED_FIRST, 32'sh1234_5678);
		send_request(OP_RESERVED_FIRST + 1'b1, -32'sd1);
		send_request(OP_RESERVED_LAST, '0);
		send_request(OP_PUSH_FRONT, 32'sh7fff_ffff);
		send_request(OP_PEEK_FRONT, '0);
		send_request(OP_POP_BACK, '0);
		send_request(OP_PUSH_BACK, 32'sh8000_0000);
		// The head steps back across slot zero here.
		send_request(OP_PUSH_FRONT, '0);
		send_request(OP_PUSH_BACK, -32'sd1);
		send_request(OP_PUSH_FRONT, 32'sh5555_5555);
		send_request(OP_PEEK_FRONT, -32'sd1);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_FRONT, 32'shaaaa_aaaa);
		send_request(OP_RESERVED_LAST, 32'shffff_ffff);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_BACK, '0);
		drain();
	endtask

	task automatic test_fill_drain(input int rounds);
		int level;
		for (int r = 0; r < rounds; r++) begin
			level = int'(ring_count);
			while (level < DEPTH) begin
				send_request(pick_push(), pick_value());
				level++;
			end
			send_request(pick_push(), pick_value());
			send_request(pick_push(), pick_value());
			send_request(OP_PEEK_FRONT, pick_value());
			send_request(pick_reserved(), pick_value());
			while (level > 0) begin
				send_request(pick_pop(), pick_value());
				level--;
			end
			send_request(pick_pop(), pick_value());
			send_request(OP_PEEK_FRONT, pick_value());
			drain();
		end
	endtask

	// Bursts lean toward pushes or pops in turn so the queue swings between
	// its empty and full ends.
	task automatic test_random_mix(input int bursts, input int burst_len);
		int push_pct;
		for (int b = 0; b < bursts; b++) begin
			push_pct = (b % 2 == 0) ? 70 : 30;
			for (int i = 0; i < burst_len; i++)
				send_request(pick_op(push_pct), pick_value());
		end
		drain();
	endtask

	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		for (int i = 0; i < count; i++)
			send_request(pick_op(50), pick_value());
		drain();
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_PUSH_BACK;
		req_ch.value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_drain(3);
		test_random_mix(5, 50);
		test_back_to_back(90);

		if (mismatches == 0)
			$display("PASS circular_deque_core");
		else
			$display("FAIL circular_deque_core");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL circular_deque_core");
		$finish;
	end

endmodule
